/* hdl/omst_pkg.sv */
// ----------------------------------------------------------------------------
// omst_pkg
// Shared types, request and slot state codes, and helper functions for the
// outstanding message slot table.
// ----------------------------------------------------------------------------
package omst_pkg;

  localparam int MAX_SLOTS = 8;
  localparam int DEF_SLOTS = 8;
  localparam int IDX_W     = 3;
  localparam int CNT_W     = 4;
  localparam int TRANS_W   = 16;
  localparam int REQ_W     = 3;

  localparam logic [CNT_W-1:0] CFG_RESET = 4'd8;

  localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_MATCH   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SEND    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ABORT   = 3'd4;

  localparam logic [1:0] ST_UNUSED = 2'd0;
  localparam logic [1:0] ST_PEND   = 2'd1;
  localparam logic [1:0] ST_TX     = 2'd2;

  typedef logic [MAX_SLOTS-1:0] slot_mask_t;

  typedef struct packed {
    logic load_req;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic step_last;
  } dp_status_t;

  // priority encoder, lowest set bit wins
  function automatic logic [IDX_W-1:0] lowest_idx(input slot_mask_t m);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (m[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

  function automatic slot_mask_t idx_onehot(input logic [IDX_W-1:0] idx);
    return slot_mask_t'(1) << idx;
  endfunction

endpackage

/* hdl/omst_ctrl.sv */
// ----------------------------------------------------------------------------
// omst_ctrl
// Sequencer: takes one request word, then steps the datapath until the last
// result word of that request has been loaded into the output register.
// ----------------------------------------------------------------------------
module omst_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  omst_pkg::dp_status_t status,
  output omst_pkg::dp_cmd_t    cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.load_req = 1'b0;
    cmd.step     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.step_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/omst_datapath.sv */
// ----------------------------------------------------------------------------
// omst_datapath
// Slot table, request register, priority encoders and output register.
// One step performs one request, or frees one slot of an abort-all.
// ----------------------------------------------------------------------------
module omst_datapath #(
  parameter int SLOTS = omst_pkg::DEF_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [omst_pkg::CNT_W-1:0]        cfg_wr_data,
  input  logic [omst_pkg::REQ_W-1:0]        in_req_type,
  input  logic [omst_pkg::TRANS_W-1:0]      in_trans_number,
  input  logic                              in_is_command,
  input  logic [omst_pkg::IDX_W-1:0]        in_slot_sel,
  input  logic                              in_out_room,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [omst_pkg::IDX_W-1:0]        out_slot_index,
  output logic                              out_error_code,
  output logic                              out_last,
  input  omst_pkg::dp_cmd_t                 cmd,
  output omst_pkg::dp_status_t              status
);

  // only the first eight slots can ever be addressed
  localparam int TBL = (SLOTS < omst_pkg::MAX_SLOTS) ? SLOTS : omst_pkg::MAX_SLOTS;
  localparam logic [omst_pkg::CNT_W-1:0] TBL_N = omst_pkg::CNT_W'(TBL);

  logic [omst_pkg::CNT_W-1:0]   cfg_r;
  logic [omst_pkg::IDX_W-1:0]   cur_r, cur_nxt;
  logic [omst_pkg::REQ_W-1:0]   req_type_r;
  logic [omst_pkg::TRANS_W-1:0] trans_r;
  logic                         is_cmd_r;
  logic [omst_pkg::IDX_W-1:0]   sel_r;
  logic                         room_r;

  logic [1:0]                   slot_state_r [TBL];
  logic [omst_pkg::TRANS_W-1:0] slot_trans_r [TBL];
  logic                         slot_cmd_r   [TBL];

  logic                         out_valid_r, out_valid_nxt;
  logic                         found_r;
  logic [omst_pkg::IDX_W-1:0]   idx_r;
  logic                         err_r;
  logic                         last_r;

  logic [omst_pkg::CNT_W-1:0]   n_cnt;
  omst_pkg::slot_mask_t         act, used, pend, tx, hit, free_m, ge_m, pend_hi;
  omst_pkg::slot_mask_t         alloc_oh, tx_oh, clr_oh, cur_oh, sel_oh, ab_oh;
  logic [omst_pkg::IDX_W-1:0]   start, pick, ab_idx, free_idx;
  logic                         cur_tx;

  logic                         res_found, res_err, res_last;
  logic [omst_pkg::IDX_W-1:0]   res_idx;

  // effective slot count, clamped to 1..TBL
  always_comb begin
    if (cfg_r == '0) n_cnt = omst_pkg::CNT_W'(1);
    else if (cfg_r > TBL_N) n_cnt = TBL_N;
    else n_cnt = cfg_r;
  end

  genvar g;
  for (g = 0; g < omst_pkg::MAX_SLOTS; g++) begin : g_mask
    assign act[g]  = (omst_pkg::CNT_W'(g) < n_cnt);
    assign ge_m[g] = (omst_pkg::IDX_W'(g) >= start);
    if (g < TBL) begin : g_live
      assign used[g] = act[g] && (slot_state_r[g] != omst_pkg::ST_UNUSED);
      assign pend[g] = act[g] && (slot_state_r[g] == omst_pkg::ST_PEND);
      assign tx[g]   = act[g] && (slot_state_r[g] == omst_pkg::ST_TX);
      assign hit[g]  = used[g] && slot_cmd_r[g] && (slot_trans_r[g] == trans_r);
    end else begin : g_pad
      assign used[g] = 1'b0;
      assign pend[g] = 1'b0;
      assign tx[g]   = 1'b0;
      assign hit[g]  = 1'b0;
    end
  end

  assign free_m   = act & ~used;
  assign free_idx = omst_pkg::lowest_idx(free_m);
  assign cur_oh   = omst_pkg::idx_onehot(cur_r);
  assign sel_oh   = omst_pkg::idx_onehot(sel_r);
  assign cur_tx   = |(tx & cur_oh);
  assign start    = (({1'b0, cur_r} + omst_pkg::CNT_W'(1)) >= n_cnt) ? '0 : cur_r + 1'b1;
  // round-robin: first pending at or after start, else wrap to lowest pending
  assign pend_hi  = pend & ge_m;
  assign pick     = (|pend_hi) ? omst_pkg::lowest_idx(pend_hi) : omst_pkg::lowest_idx(pend);
  assign ab_idx   = omst_pkg::lowest_idx(used);
  assign ab_oh    = omst_pkg::idx_onehot(ab_idx);

  always_comb begin
    res_found = 1'b0;
    res_idx   = '0;
    res_err   = 1'b0;
    res_last  = 1'b1;
    alloc_oh  = '0;
    tx_oh     = '0;
    clr_oh    = '0;
    cur_nxt   = cur_r;
    case (req_type_r)
      omst_pkg::REQ_ALLOC: begin
        if (|free_m) begin
          res_found = 1'b1;
          res_idx   = free_idx;
          alloc_oh  = omst_pkg::idx_onehot(free_idx);
        end
      end
      omst_pkg::REQ_MATCH: begin
        if (|hit) begin
          res_found = 1'b1;
          res_idx   = omst_pkg::lowest_idx(hit);
        end
      end
      omst_pkg::REQ_SEND: begin
        if (cur_tx) begin
          res_idx = cur_r;
        end else if (|pend) begin
          cur_nxt = pick;
          res_idx = pick;
          if (room_r) begin
            res_found = 1'b1;
            tx_oh     = omst_pkg::idx_onehot(pick);
          end else begin
            res_err = 1'b1;
          end
        end else begin
          cur_nxt = start;
          res_idx = start;
        end
      end
      omst_pkg::REQ_RELEASE: begin
        res_idx   = sel_r;
        res_found = |(used & sel_oh);
        clr_oh    = sel_oh & act;
      end
      omst_pkg::REQ_ABORT: begin
        // one slot per step, last once nothing else remains in use
        if (|used) begin
          res_found = 1'b1;
          res_idx   = ab_idx;
          clr_oh    = ab_oh;
          res_last  = ((used & ~ab_oh) == '0);
        end
      end
      default: ;
    endcase
  end

  for (g = 0; g < TBL; g++) begin : g_slot
    logic [1:0] state_nxt;
    always_comb begin
      state_nxt = slot_state_r[g];
      if (cmd.step) begin
        if (alloc_oh[g]) state_nxt = omst_pkg::ST_PEND;
        else if (tx_oh[g]) state_nxt = omst_pkg::ST_TX;
        else if (clr_oh[g]) state_nxt = omst_pkg::ST_UNUSED;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        slot_state_r[g] <= omst_pkg::ST_UNUSED;
      end else begin
        slot_state_r[g] <= state_nxt;
      end
    end
    always_ff @(posedge clk) begin
      if (cmd.step && alloc_oh[g]) begin
        slot_trans_r[g] <= trans_r;
        slot_cmd_r[g]   <= is_cmd_r;
      end
    end
  end

  assign out_valid_nxt = cmd.step ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= omst_pkg::CFG_RESET;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      if (cmd.step) cur_r <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type_r <= in_req_type;
      trans_r    <= in_trans_number;
      is_cmd_r   <= in_is_command;
      sel_r      <= in_slot_sel;
      room_r     <= in_out_room;
    end
    if (cmd.step) begin
      found_r <= res_found;
      idx_r   <= res_idx;
      err_r   <= res_err;
      last_r  <= res_last;
    end
  end

  assign status.out_free  = !out_valid_r || !out_stall;
  assign status.step_last = res_last;

  assign out_valid      = out_valid_r;
  assign out_found      = found_r;
  assign out_slot_index = idx_r;
  assign out_error_code = err_r;
  assign out_last       = last_r;

endmodule

/* hdl/outstanding_message_slot_table_unit.sv */
// ----------------------------------------------------------------------------
// outstanding_message_slot_table_unit
// Table of up to eight message slots (unused, pending, transmitting) with
// allocate, match, round-robin send-next, release and abort-all requests.
// A request word is loaded into the request register in the idle state and
// executed in the exec state; abort-all gives one result word per freed slot,
// one per cycle while the output is not stalled, or a single word when no
// slot is in use. The output register lets the sequencer stall only when a
// result cannot be loaded. Slot count may be written through
// cfg_wr_en/cfg_wr_data only while no request is open.
// ----------------------------------------------------------------------------
module outstanding_message_slot_table_unit #(
  parameter int SLOTS = omst_pkg::DEF_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [omst_pkg::CNT_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [omst_pkg::REQ_W-1:0]    in_req_type,
  input  logic [omst_pkg::TRANS_W-1:0]  in_trans_number,
  input  logic                          in_is_command,
  input  logic [omst_pkg::IDX_W-1:0]    in_slot_sel,
  input  logic                          in_out_room,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [omst_pkg::IDX_W-1:0]    out_slot_index,
  output logic                          out_error_code,
  output logic                          out_last
);

  omst_pkg::dp_cmd_t    cmd;
  omst_pkg::dp_status_t status;

  omst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  omst_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_req_type     (in_req_type),
    .in_trans_number (in_trans_number),
    .in_is_command   (in_is_command),
    .in_slot_sel     (in_slot_sel),
    .in_out_room     (in_out_room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_slot_index  (out_slot_index),
    .out_error_code  (out_error_code),
    .out_last        (out_last),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

/* hdl/omst_checker.sv */
// ----------------------------------------------------------------------------
// omst_checker
// Port-level checks for the slot table, bound to the top level.
// ----------------------------------------------------------------------------
module omst_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_found,
  input logic [omst_pkg::IDX_W-1:0]   out_slot_index,
  input logic                         out_error_code,
  input logic                         out_last
);

  // a held result word keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) &&
      $stable(out_slot_index) && $stable(out_error_code) && $stable(out_last))
    else $error("result word changed while stalled");

  // one request at a time: busy right after a word is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still open");

  // output full is a failed, single-word send result
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code |-> !out_found && out_last)
    else $error("error word with found or without last");

  // only abort-all gives more than one word, and each of those frees a slot
  a_multi_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_found)
    else $error("non-final word without found");

endmodule

bind outstanding_message_slot_table_unit omst_checker u_omst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_found      (out_found),
  .out_slot_index (out_slot_index),
  .out_error_code (out_error_code),
  .out_last       (out_last)
);

/* tb/slot_table_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_scoreboard_pkg
// Scoreboard for the message slot table: keeps its own copy of the slot
// table and works out the result words that each accepted request causes.
// ----------------------------------------------------------------------------
package slot_table_scoreboard_pkg;

  import omst_pkg::*;

  typedef struct {
    bit                 found;
    bit [IDX_W-1:0]     slot_index;
    bit                 error_code;
    bit                 last;
  } slot_result_t;

  class slot_table_scoreboard;

    bit [1:0]         slot_st    [MAX_SLOTS];
    bit [TRANS_W-1:0] slot_trans [MAX_SLOTS];
    bit               slot_cmd   [MAX_SLOTS];
    int               cur_slot;
    bit [CNT_W-1:0]   slot_count;
    slot_result_t     pending_results[$];
    int               errors;
    int               checked;

    function new();
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_st[i]    = ST_UNUSED;
        slot_trans[i] = '0;
        slot_cmd[i]   = 1'b0;
      end
      cur_slot   = 0;
      slot_count = CFG_RESET;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_slot_count(bit [CNT_W-1:0] v);
      slot_count = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // register value clamped to 1..MAX_SLOTS
    function int active_slots();
      int n;
      n = slot_count;
      if (n < 1) n = 1;
      if (n > MAX_SLOTS) n = MAX_SLOTS;
      return n;
    endfunction

    function void push_result(bit f, int idx, bit e, bit l);
      slot_result_t r;
      r.found      = f;
      r.slot_index = idx[IDX_W-1:0];
      r.error_code = e;
      r.last       = l;
      pending_results.push_back(r);
    endfunction

    function int step_slot(int c, int n);
      return (c + 1 >= n) ? 0 : c + 1;
    endfunction

    function void note_request(bit [REQ_W-1:0] req, bit [TRANS_W-1:0] tn, bit cmd,
                               bit [IDX_W-1:0] sel, bit room);
      int  n;
      int  c;
      int  total;
      int  sent;
      bit  done;
      bit  was;
      n    = active_slots();
      done = 1'b0;
      case (req)
        REQ_ALLOC: begin
          for (int i = 0; i < n; i++) begin
            if (!done && slot_st[i] == ST_UNUSED) begin
              slot_st[i]    = ST_PEND;
              slot_trans[i] = tn;
              slot_cmd[i]   = cmd;
              push_result(1'b1, i, 1'b0, 1'b1);
              done = 1'b1;
            end
          end
          if (!done) push_result(1'b0, 0, 1'b0, 1'b1);
        end
        REQ_MATCH: begin
          for (int i = 0; i < n; i++) begin
            if (!done && slot_st[i] != ST_UNUSED && slot_cmd[i] && slot_trans[i] == tn) begin
              push_result(1'b1, i, 1'b0, 1'b1);
              done = 1'b1;
            end
          end
          if (!done) push_result(1'b0, 0, 1'b0, 1'b1);
        end
        REQ_SEND: begin
          c = cur_slot;
          if (c < n && slot_st[c] == ST_TX) begin
            push_result(1'b0, c, 1'b0, 1'b1);
          end else begin
            c = step_slot(c, n);
            for (int k = 0; k < n && !done; k++) begin
              if (slot_st[c] == ST_PEND) begin
                cur_slot = c;
                if (room) begin
                  slot_st[c] = ST_TX;
                  push_result(1'b1, c, 1'b0, 1'b1);
                end else begin
                  push_result(1'b0, c, 1'b1, 1'b1);
                end
                done = 1'b1;
              end else begin
                c = step_slot(c, n);
              end
            end
            if (!done) begin
              cur_slot = c;
              push_result(1'b0, c, 1'b0, 1'b1);
            end
          end
        end
        REQ_RELEASE: begin
          was = 1'b0;
          if (sel < n) begin
            was = (slot_st[sel] != ST_UNUSED);
            slot_st[sel] = ST_UNUSED;
          end
          push_result(was, sel, 1'b0, 1'b1);
        end
        REQ_ABORT: begin
          total = 0;
          sent  = 0;
          for (int i = 0; i < n; i++)
            if (slot_st[i] != ST_UNUSED) total++;
          for (int i = 0; i < n; i++) begin
            if (slot_st[i] != ST_UNUSED) begin
              slot_st[i] = ST_UNUSED;
              sent++;
              push_result(1'b1, i, 1'b0, sent == total);
            end
          end
          if (total == 0) push_result(1'b0, 0, 1'b0, 1'b1);
        end
        default: push_result(1'b0, 0, 1'b0, 1'b1);
      endcase
    endfunction

    task report(string what);
      $display("tb: MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(bit f, bit [IDX_W-1:0] idx, bit e, bit l);
      slot_result_t x;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result word found=%0d slot=%0d err=%0d last=%0d",
                         f, idx, e, l));
      end else begin
        x = pending_results.pop_front();
        if (f !== x.found)
          report($sformatf("found %0d, expected %0d", f, x.found));
        if (idx !== x.slot_index)
          report($sformatf("slot_index %0d, expected %0d", idx, x.slot_index));
        if (e !== x.error_code)
          report($sformatf("error_code %0d, expected %0d", e, x.error_code));
        if (l !== x.last)
          report($sformatf("last %0d, expected %0d", l, x.last));
      end
    endtask

  endclass

endpackage

/* tb/tb_outstanding_message_slot_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_outstanding_message_slot_table_unit
// Drives allocate, match, send-next, release and abort-all requests into the
// slot table under several slot counts, with random gaps and output stalls,
// and checks every result word against a scoreboard that tracks the table.
// ----------------------------------------------------------------------------
module tb_outstanding_message_slot_table_unit;

  import omst_pkg::*;
  import slot_table_scoreboard_pkg::*;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                cfg_wr_en       = 1'b0;
  logic [CNT_W-1:0]    cfg_wr_data     = '0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    in_req_type     = REQ_ALLOC;
  logic [TRANS_W-1:0]  in_trans_number = '0;
  logic                in_is_command   = 1'b0;
  logic [IDX_W-1:0]    in_slot_sel     = '0;
  logic                in_out_room     = 1'b0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic                out_found;
  logic [IDX_W-1:0]    out_slot_index;
  logic                out_error_code;
  logic                out_last;

  slot_table_scoreboard table_sb = new();

  int words_sent   = 0;
  int count_writes = 0;
  bit no_gaps      = 1'b0;
  bit hold_out     = 1'b0;
  bit holding      = 1'b0;

  outstanding_message_slot_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_trans_number (in_trans_number),
    .in_is_command   (in_is_command),
    .in_slot_sel     (in_slot_sel),
    .in_out_room     (in_out_room),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found       (out_found),
    .out_slot_index  (out_slot_index),
    .out_error_code  (out_error_code),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // result side: values read straight after the edge are the pre-edge ones
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        table_sb.check_result(out_found, out_slot_index, out_error_code, out_last);
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  initial begin
    int r;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        holding = 1'b1;
        out_stall <= 1'b1;
        repeat (64) @(posedge clk);
        hold_out = 1'b0;
        holding  = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else if (r < 80) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 92) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(15, 40)) @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat ($urandom_range(5, 25)) @(posedge clk);
        end
      end
    end
  end

  task automatic idle_gap();
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!no_gaps) begin
      if (r >= 60 && r < 90) gap = $urandom_range(1, 3);
      else if (r >= 90) gap = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // offer one request word and hold it until taken
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [TRANS_W-1:0] tn,
                           input logic cmd, input logic [IDX_W-1:0] sel,
                           input logic room);
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_trans_number <= tn;
    in_is_command   <= cmd;
    in_slot_sel     <= sel;
    in_out_room     <= room;
    do @(posedge clk); while (in_stall);
    table_sb.note_request(req, tn, cmd, sel, room);
    words_sent++;
    idle_gap();
  endtask

  task automatic wait_drained();
    while (table_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [CNT_W-1:0] v);
    in_valid <= 1'b0;
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    table_sb.set_slot_count(v);
    count_writes++;
  endtask

  task automatic directed_words();
    // full table of eight: empty abort, allocate, match, send, release and undefined request cases
    send_word(REQ_ABORT,   16'h0000, 1'b0, 3'd0, 1'b1);
    send_word(REQ_ALLOC,   16'h0000, 1'b1, 3'd0, 1'b1);
    send_word(REQ_ALLOC,   16'hFFFF, 1'b1, 3'd7, 1'b0);
    send_word(REQ_ALLOC,   16'hA5A5, 1'b0, 3'd0, 1'b1);
    send_word(REQ_MATCH,   16'hFFFF, 1'b0, 3'd0, 1'b1);
    send_word(REQ_MATCH,   16'hA5A5, 1'b1, 3'd0, 1'b1);
    send_word(REQ_MATCH,   16'h1234, 1'b0, 3'd0, 1'b1);
    send_word(REQ_SEND,    16'h0000, 1'b0, 3'd0, 1'b0);
    send_word(REQ_SEND,    16'h0000, 1'b0, 3'd0, 1'b1);
    send_word(REQ_SEND,    16'h5A5A, 1'b1, 3'd7, 1'b1);
    send_word(REQ_RELEASE, 16'h0000, 1'b0, 3'd2, 1'b1);
    send_word(REQ_RELEASE, 16'h0000, 1'b0, 3'd2, 1'b1);
    send_word(REQ_SEND,    16'h0000, 1'b0, 3'd0, 1'b1);
    send_word(REQ_RELEASE, 16'hFFFF, 1'b1, 3'd7, 1'b0);
    send_word(REQ_ABORT + 3'd1, 16'hFFFF, 1'b1, 3'd7, 1'b1);
    send_word(REQ_ABORT + 3'd2, 16'h0000, 1'b0, 3'd0, 1'b0);
    send_word(REQ_ABORT + 3'd3, 16'h8001, 1'b1, 3'd5, 1'b1);
    send_word(REQ_ABORT,   16'h0000, 1'b0, 3'd0, 1'b1);
    send_word(REQ_SEND,    16'h0000, 1'b0, 3'd0, 1'b1);
    // one slot: current slot beyond the count, table full, release beyond count
    write_slot_count(4'd1);
    send_word(REQ_SEND,    16'h0000, 1'b0, 3'd0, 1'b1);
    send_word(REQ_ALLOC,   16'h7E7E, 1'b1, 3'd0, 1'b1);
    send_word(REQ_ALLOC,   16'h0101, 1'b1, 3'd0, 1'b1);
    send_word(REQ_MATCH,   16'h7E7E, 1'b0, 3'd0, 1'b1);
    send_word(REQ_RELEASE, 16'h0000, 1'b0, 3'd5, 1'b1);
    send_word(REQ_ABORT,   16'h0000, 1'b0, 3'd0, 1'b1);
  endtask

  // mostly well-formed traffic aimed at live slots, with some noise
  task automatic random_words(input int count);
    int r;
    int s;
    int j;
    logic [REQ_W-1:0]   req;
    logic [TRANS_W-1:0] tn;
    logic               c;
    logic [IDX_W-1:0]   sel;
    logic               room;
    for (int w = 0; w < count; w++) begin
      r    = $urandom_range(0, 99);
      tn   = TRANS_W'($urandom);
      c    = ($urandom_range(0, 3) != 0);
      sel  = IDX_W'($urandom);
      room = ($urandom_range(0, 3) != 0);
      s    = $urandom_range(0, MAX_SLOTS - 1);
      if (r < 30) begin
        req = REQ_ALLOC;
      end else if (r < 55) begin
        req = REQ_SEND;
      end else if (r < 70) begin
        req = REQ_MATCH;
        if ($urandom_range(0, 3) != 0) begin
          for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
            j = (s + k) % MAX_SLOTS;
            if (table_sb.slot_st[j] != ST_UNUSED && table_sb.slot_cmd[j])
              tn = table_sb.slot_trans[j];
          end
        end
      end else if (r < 86) begin
        req = REQ_RELEASE;
        if ($urandom_range(0, 2) != 0) begin
          for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
            j = (s + k) % MAX_SLOTS;
            if (table_sb.slot_st[j] != ST_UNUSED) sel = IDX_W'(j);
          end
        end
      end else if (r < 94) begin
        req = REQ_ABORT;
      end else begin
        req = REQ_W'($urandom_range(int'(REQ_ABORT) + 1, (1 << REQ_W) - 1));
      end
      send_word(req, tn, c, sel, room);
    end
  endtask

  // back-to-back words while the output is held off, so the input backs up
  task automatic pressure_burst();
    in_valid <= 1'b0;
    hold_out = 1'b1;
    @(posedge clk);
    wait (holding);
    no_gaps = 1'b1;
    for (int w = 0; w < 14; w++) begin
      if (w % 3 == 2)
        send_word(REQ_SEND, TRANS_W'($urandom), 1'b1, 3'd0, 1'b1);
      else
        send_word(REQ_ALLOC, TRANS_W'($urandom), 1'($urandom), 3'd0, 1'b1);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_words();

    write_slot_count(4'd15);
    random_words(16);
    pressure_burst();
    write_slot_count(4'd3);
    random_words(16);
    write_slot_count(4'd0);
    random_words(10);
    write_slot_count(4'd6);
    no_gaps = 1'b1;
    random_words(12);
    no_gaps = 1'b0;
    write_slot_count(4'd8);
    random_words(16);

    in_valid <= 1'b0;
    wait_drained();
    repeat (12) @(posedge clk);

    $display("tb: %0d request words sent, %0d result words checked", words_sent,
             table_sb.checked);
    $display("tb: %0d slot-count writes, output held off once with input backed up",
             count_writes);
    if (table_sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
